### design/assert_macros.svh
// assertion macros for the rtl files, included only by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BEM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BEM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/bem_pkg.sv
// shared types, constants and log table of the byte entropy meter
package bem_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int LOG_FRAC       = 24;
	localparam int SEG_BITS       = 5;
	localparam int REM_BITS       = 26;
	localparam int LOG_W          = 30;
	localparam int ENT_W          = 20;
	localparam int CNT_W          = 24;
	localparam int BYTE_W         = 8;
	localparam int M_DATA_W       = 48;
	localparam int BINS           = 256;
	localparam int SEG_N          = 2 ** SEG_BITS;

	typedef logic [LOG_FRAC:0] seg_val_t;
	typedef seg_val_t seg_tab_t [SEG_N+1];

	// log2(1 + i/32) with 24 fraction bits, by repeated squaring
	function automatic seg_val_t seg_log(int unsigned i);
		logic [63:0] y;
		seg_val_t    acc;
		acc = '0;
		if (i >= SEG_N) begin
			acc = seg_val_t'(1) << LOG_FRAC;
		end else begin
			y = (64'd1 << 30) + (64'(i) << 25);
			for (int k = 0; k < LOG_FRAC; k++) begin
				y   = (y * y) >> 30;
				acc = acc << 1;
				if (y >= (64'd1 << 31)) begin
					acc[0] = 1'b1;
					y      = y >> 1;
				end
			end
		end
		return acc;
	endfunction

	function automatic seg_tab_t build_seg_tab();
		seg_tab_t t;
		for (int i = 0; i <= SEG_N; i++) begin
			t[i] = seg_log(i);
		end
		return t;
	endfunction

	localparam seg_tab_t SEG_TAB = build_seg_tab();

	typedef struct packed {
		logic accept;
		logic log_start;
		logic log_sel_n;
		logic ln_load;
		logic idx_clr;
		logic idx_inc;
		logic c_load;
		logic mul_load;
		logic acc_clr;
		logic acc_add;
		logic div_start;
		logic out_load;
		logic clear;
	} bem_cmd_t;

	typedef struct packed {
		logic log_done;
		logic c_zero;
		logic idx_last;
		logic div_done;
		logic out_free;
	} bem_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_LOGN_W,
		ST_RD,
		ST_LOAD,
		ST_LOGC_W,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_DIV_W,
		ST_FIN
	} bem_state_t;

endpackage

### design/bem_log2.sv
// iterative fixed-point log2: normalise one bit a cycle, then interpolate
module bem_log2 #(
	parameter int COUNT_BITS = bem_pkg::COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COUNT_BITS-1:0]    x,
	output logic                     done,
	output logic [bem_pkg::LOG_W-1:0] l
);
	import bem_pkg::*;

	localparam int SH_W = $clog2(COUNT_BITS);

	logic [COUNT_BITS-1:0]        norm_q;
	logic [SH_W-1:0]              sh_q;
	logic                         busy_q;
	logic                         ph_q;
	logic                         done_q;
	logic [REM_BITS+LOG_FRAC:0]   prod_s1;
	logic [LOG_W-1:0]             base_s1;
	logic [LOG_W-1:0]             l_q;

	logic [COUNT_BITS+30:0] cat;
	logic [30:0]            m;
	logic [SEG_BITS-1:0]    seg;
	logic [REM_BITS-1:0]    r;
	seg_val_t               t0;
	seg_val_t               t1;
	seg_val_t               diff;
	logic [4:0]             p;
	logic [LOG_W-1:0]       base;

	always_comb begin
		cat  = {norm_q, 31'b0};
		m    = cat[COUNT_BITS+29:COUNT_BITS-1];
		seg  = m[30:REM_BITS];
		r    = m[REM_BITS-1:0];
		t0   = SEG_TAB[seg];
		t1   = SEG_TAB[{1'b0, seg} + 6'd1];
		diff = t1 - t0;
		p    = 5'(COUNT_BITS - 1) - 5'(sh_q);
		base = LOG_W'({p, {LOG_FRAC{1'b0}}}) + LOG_W'(t0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				norm_q <= (x == '0) ? COUNT_BITS'(1) : x;
				sh_q   <= '0;
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
			end else if (busy_q) begin
				if (!ph_q) begin
					if (!norm_q[COUNT_BITS-1]) begin
						norm_q <= norm_q << 1;
						sh_q   <= sh_q + SH_W'(1);
					end else begin
						prod_s1 <= diff * r;
						base_s1 <= base;
						ph_q    <= 1'b1;
					end
				end else begin
					l_q    <= base_s1 + LOG_W'(prod_s1 >> REM_BITS);
					busy_q <= 1'b0;
					ph_q   <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign l    = l_q;

endmodule

### design/bem_div.sv
// restoring divider, one quotient bit a cycle
module bem_div #(
	parameter int NUM_W = 54,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	import bem_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] sub;
	logic           ge;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		sub   = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				den_q  <= den;
				quo_q  <= num;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### design/bem_dp.sv
// datapath: histogram memory, counters, log and divide units, result register
`include "assert_macros.svh"
module bem_dp #(
	parameter int COUNT_BITS = bem_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = bem_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bem_pkg::bem_cmd_t          cmd,
	output bem_pkg::bem_sts_t          sts,
	input  logic [bem_pkg::BYTE_W-1:0] in_byte,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [bem_pkg::ENT_W-1:0]  out_entropy,
	output logic [bem_pkg::CNT_W-1:0]  out_count,
	output logic                       out_ovf
);
	import bem_pkg::*;

	localparam int SUM_W = COUNT_BITS + LOG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] mem [BINS];
	logic [BINS-1:0]       vld_q;
	logic [BYTE_W-1:0]     rd_addr;
	logic [COUNT_BITS-1:0] rdata_s1;
	logic                  rvld_s1;
	logic                  fwd_s1;
	logic [COUNT_BITS-1:0] fwd_val_s1;
	logic                  inc_s1;
	logic [BYTE_W-1:0]     addr_s1;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] wval;

	logic [COUNT_BITS-1:0] tot_q;
	logic                  ovf_q;
	logic                  full;
	logic [BYTE_W-1:0]     idx_q;
	logic [COUNT_BITS-1:0] c_q;
	logic [LOG_W-1:0]      ln_q;
	logic [SUM_W-1:0]      prod_q;
	logic [SUM_W-1:0]      acc_q;

	logic [COUNT_BITS-1:0] log_x;
	logic                  log_done;
	logic [LOG_W-1:0]      l_out;
	logic                  div_done;
	logic [SUM_W-1:0]      quo;

	logic [SUM_W-1:0]      h24;
	logic [SUM_W-1:0]      hsh;
	logic [ENT_W-1:0]      ent;
	logic [32:0]           tot_w;
	logic [CNT_W-1:0]      cnt_sat;

	logic                  out_vld_q;
	logic [ENT_W-1:0]      ent_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  oflag_q;

	// bin value, with bypass of the write still in flight
	always_comb begin
		rd_addr = cmd.accept ? in_byte : idx_q;
		cur     = fwd_s1 ? fwd_val_s1 : (rvld_s1 ? rdata_s1 : '0);
		wval    = cur + COUNT_BITS'(1);
		full    = tot_q == CNT_MAX;
		log_x   = cmd.log_sel_n ? tot_q : cur;
	end

	always_ff @(posedge clk) begin
		if (inc_s1) begin
			mem[addr_s1] <= wval;
		end
		rdata_s1   <= mem[rd_addr];
		fwd_val_s1 <= wval;
		addr_s1    <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
			inc_s1  <= 1'b0;
			tot_q   <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			rvld_s1 <= vld_q[rd_addr];
			fwd_s1  <= inc_s1 && (addr_s1 == rd_addr);
			inc_s1  <= cmd.accept && !full;
			if (cmd.clear) begin
				vld_q <= '0;
				tot_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (inc_s1) begin
					vld_q[addr_s1] <= 1'b1;
				end
				if (cmd.accept) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						tot_q <= tot_q + COUNT_BITS'(1);
					end
				end
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + BYTE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.c_load) begin
			c_q <= cur;
		end
		if (cmd.ln_load) begin
			ln_q <= l_out;
		end
		if (cmd.mul_load) begin
			prod_q <= c_q * l_out;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
	end

	bem_log2 #(
		.COUNT_BITS(COUNT_BITS)
	) u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.log_start),
		.x     (log_x),
		.done  (log_done),
		.l     (l_out)
	);

	bem_div #(
		.NUM_W(SUM_W),
		.DEN_W(COUNT_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (acc_q),
		.den   (tot_q),
		.done  (div_done),
		.quo   (quo)
	);

	// final subtract, scale and saturate
	always_comb begin
		h24 = (SUM_W'(ln_q) > quo) ? (SUM_W'(ln_q) - quo) : '0;
		hsh = h24 >> (LOG_FRAC - FRAC_BITS);
		if (tot_q == '0) begin
			ent = '0;
		end else if (hsh > SUM_W'({ENT_W{1'b1}})) begin
			ent = '1;
		end else begin
			ent = hsh[ENT_W-1:0];
		end
		tot_w   = 33'(tot_q);
		cnt_sat = (tot_w > 33'({CNT_W{1'b1}})) ? '1 : tot_w[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ent_q   <= ent;
			cnt_q   <= cnt_sat;
			oflag_q <= ovf_q;
		end
	end

	always_comb begin
		sts.log_done = log_done;
		sts.c_zero   = cur == '0;
		sts.idx_last = idx_q == '1;
		sts.div_done = div_done;
		sts.out_free = !out_vld_q || out_ready;
	end

	assign out_valid   = out_vld_q;
	assign out_entropy = ent_q;
	assign out_count   = cnt_q;
	assign out_ovf     = oflag_q;

	`BEM_ASSERT_IMP(a_ovf_only_full, ovf_q, tot_q == CNT_MAX, "overflow flag without full count")
	`BEM_ASSERT_NXT(a_clear_all, cmd.clear, (tot_q == '0) && !ovf_q && (vld_q == '0), "clear left state")
	`BEM_ASSERT_IMP(a_no_inc_in_pass, inc_s1, !(cmd.c_load || cmd.idx_inc), "bin write during pass")

endmodule

### design/bem_ctrl.sv
// controller: sequences histogram fill and the per-buffer entropy pass
module bem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  bem_pkg::bem_sts_t sts,
	output bem_pkg::bem_cmd_t cmd
);
	import bem_pkg::*;

	bem_state_t state_q;
	bem_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_LOGN_W;
			ST_LOGN_W: begin
				if (sts.log_done) state_d = ST_RD;
			end
			ST_RD:     state_d = ST_LOAD;
			ST_LOAD: begin
				if (!sts.c_zero) state_d = ST_LOGC_W;
				else if (sts.idx_last) state_d = ST_DIV;
				else state_d = ST_RD;
			end
			ST_LOGC_W: begin
				if (sts.log_done) state_d = ST_MUL;
			end
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = sts.idx_last ? ST_DIV : ST_RD;
			ST_DIV:    state_d = ST_DIV_W;
			ST_DIV_W: begin
				if (sts.div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DRAIN: begin
				cmd.log_start = 1'b1;
				cmd.log_sel_n = 1'b1;
				cmd.idx_clr   = 1'b1;
				cmd.acc_clr   = 1'b1;
			end
			ST_LOGN_W: cmd.ln_load = sts.log_done;
			ST_RD: ;
			ST_LOAD: begin
				cmd.c_load    = 1'b1;
				cmd.log_start = !sts.c_zero;
				cmd.idx_inc   = sts.c_zero;
			end
			ST_LOGC_W: ;
			ST_MUL:    cmd.mul_load = 1'b1;
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_DIV:    cmd.div_start = 1'b1;
			ST_DIV_W: ;
			ST_FIN: begin
				cmd.out_load = sts.out_free;
				cmd.clear    = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

### design/byte_entropy_meter.sv
// top level of the byte entropy meter
// usage
// - slave channel: one byte per request on s_tdata, s_tlast marks the last byte of a buffer
// - master channel: one request per buffer with entropy, byte count and overflow flag
// - bytes are taken one per cycle outside the entropy pass; each updates a 256-bin
//   histogram held in block memory through a registered read-modify-write with a
//   bypass for repeated byte values
// - after the last byte the input stalls while the entropy pass runs:
//   log2 of the count, then for each of the 256 bins a read, and for nonzero bins a
//   log2 from the one-bit-a-cycle normaliser, a multiply and an accumulate; then a
//   restoring divide
// - the result sits in an output register; histogram, count and flag clear as it loads
// - if the receiver stalls, new buffer bytes are still taken; a later result waits for
//   the register to drain
// - once the count saturates further bytes are dropped and the overflow flag is set
// - reset clears the per-bin valid flags in one step, so no clearing sweep is needed
module byte_entropy_meter #(
	parameter int COUNT_BITS = bem_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = bem_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [bem_pkg::BYTE_W-1:0]   s_tdata,   // data_byte
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bem_pkg::M_DATA_W-1:0] m_tdata,   // entropy_bits, byte_count, zero pad
	output logic                         m_tuser    // overflow
);
	import bem_pkg::*;

	bem_cmd_t          cmd;
	bem_sts_t          sts;
	logic [ENT_W-1:0]  entropy;
	logic [CNT_W-1:0]  count;
	logic              ovf;

	// sequencing of fill and entropy pass
	bem_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_last (s_tlast),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// histogram and arithmetic
	bem_dp #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_entropy(entropy),
		.out_count  (count),
		.out_ovf    (ovf)
	);

	// pack result, entropy in the low bits
	assign m_tdata = {{(M_DATA_W - ENT_W - CNT_W){1'b0}}, count, entropy};
	assign m_tuser = ovf;

endmodule

### dv/byte_entropy_meter_test.sv
// self-checking testbench for the byte entropy meter
module byte_entropy_meter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bem_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_WAIT  = 12000;

	// one expected buffer result
	typedef struct {
		logic [ENT_W-1:0] entropy;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} buf_result_t;

	// histogram predictor and store of expected buffer results
	class entropy_scoreboard;
		int unsigned       hist [BINS];
		longint unsigned   total;
		bit                ovf_seen;
		longint unsigned   seg_tab [SEG_N+1];
		buf_result_t       pending [$];
		int                errors;
		int                results_seen;
		int                bytes_seen;

		function new();
			for (int i = 0; i <= SEG_N; i++) begin
				seg_tab[i] = seg_entry(i);
			end
			wipe();
			errors = 0;
			results_seen = 0;
			bytes_seen = 0;
		endfunction

		function void wipe();
			foreach (hist[i]) begin
				hist[i] = 0;
			end
			total = 0;
			ovf_seen = 0;
		endfunction

		// log2(1 + i/32), 24 fraction bits, by repeated squaring of a 30-bit fraction
		function longint unsigned seg_entry(int unsigned i);
			longint unsigned y;
			longint unsigned acc;
			acc = 0;
			if (i >= SEG_N) begin
				return 64'd1 << LOG_FRAC;
			end
			y = (64'd1 << 30) + (64'(i) << 25);
			for (int k = 0; k < LOG_FRAC; k++) begin
				y = (y * y) >> 30;
				acc = acc << 1;
				if (y >= (64'd1 << 31)) begin
					acc = acc | 1;
					y = y >> 1;
				end
			end
			return acc;
		endfunction

		// leading-one position plus interpolated mantissa
		function longint unsigned log2_q24(longint unsigned x);
			int unsigned     msb;
			longint unsigned mant;
			longint unsigned frac;
			int unsigned     seg;
			x = x & 64'hFFFF_FFFF;
			if (x == 0) begin
				return 0;
			end
			msb = 0;
			while (msb < 31 && (x >> (msb + 1)) != 0) begin
				msb++;
			end
			mant = (x << (31 - msb)) & 64'h7FFF_FFFF;
			seg = int'(mant >> REM_BITS);
			frac = mant & ((64'd1 << REM_BITS) - 1);
			return (64'(msb) << LOG_FRAC) + seg_tab[seg]
				+ (((seg_tab[seg+1] - seg_tab[seg]) * frac) >> REM_BITS);
		endfunction

		// accepted byte request
		function void note_byte(logic [BYTE_W-1:0] b, logic is_last);
			buf_result_t     r;
			longint unsigned ln, s, q, h;
			bytes_seen++;
			if (total >= (64'd1 << COUNT_BITS_DEF) - 1) begin
				ovf_seen = 1;
			end else begin
				hist[b]++;
				total++;
			end
			if (!is_last) begin
				return;
			end
			h = 0;
			if (total != 0) begin
				ln = log2_q24(total);
				s = 0;
				foreach (hist[i]) begin
					if (hist[i] != 0) begin
						s += 64'(hist[i]) * log2_q24(hist[i]);
					end
				end
				q = s / total;
				h = (ln > q) ? ln - q : 0;
				h = h >> (LOG_FRAC - FRAC_BITS_DEF);
			end
			r.entropy = (h > 64'hFFFFF) ? '1 : h[ENT_W-1:0];
			r.count = (total > 64'hFFFFFF) ? '1 : total[CNT_W-1:0];
			r.ovf = ovf_seen;
			pending.push_back(r);
			wipe();
		endfunction

		// accepted result request
		function void check_result(logic [ENT_W-1:0] ent, logic [CNT_W-1:0] cnt, logic ovf);
			buf_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				$error("unexpected result: entropy_bits %0d byte_count %0d", ent, cnt);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ent !== e.entropy) begin
				$error("entropy_bits: expected %0d, got %0d", e.entropy, ent);
				errors++;
			end
			if (cnt !== e.count) begin
				$error("byte_count: expected %0d, got %0d", e.count, cnt);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow: expected %0d, got %0d", e.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;   // data_byte
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // entropy_bits, byte_count, zero pad
	logic                m_tuser;   // overflow

	entropy_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_off;
	int  cycles;

	byte_entropy_meter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("byte_entropy_meter_test failed");
			$finish;
		end
	end

	// long receiver hold-off, counted down in its own process
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	// result side: check every accepted result, stall at random and during the hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[ENT_W-1:0], m_tdata[ENT_W+CNT_W-1:ENT_W], m_tuser);
		end
		m_tready <= !(hold_off > 1 || $urandom_range(99) < recv_stall_pct);
	end

	// offer one byte request and wait until it is taken
	task automatic push_byte(logic [BYTE_W-1:0] b, logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, is_last);
	endtask

	// one buffer of random shape: uniform, narrow alphabet or a single repeated value
	task automatic push_random_buffer(int len, ref int sent);
		int          shape;
		logic [7:0]  base, b;
		int          span;
		shape = $urandom_range(2);
		base = 8'($urandom);
		span = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			case (shape)
				0: begin
					b = 8'($urandom);
				end
				1: begin
					b = base + 8'($urandom_range(span - 1));
				end
				default: begin
					b = base;
				end
			endcase
			push_byte(b, i == len - 1);
		end
		sent += len;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int sent;
		int quota;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		hold_off = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single byte, extreme values, two equal halves, a repeated value, four-way split, uneven mix
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h55, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'h55, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h04, 1'b0);
		push_byte(8'h08, 1'b1);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h80, 1'b1);
		s_tvalid <= 1'b0;
		wait_drained();

		// random buffers across the idling phases, mostly short ones
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			quota = sent + 65;
			if (ph == 0) begin
				hold_off <= 4000;
			end
			while (sent < quota) begin
				push_random_buffer($urandom_range(1, 12), sent);
			end
			if (ph == 3) begin
				// one long buffer of every byte value
				for (int i = 0; i < BINS; i++) begin
					push_byte(8'(i), i == BINS - 1);
				end
				sent += BINS;
			end
			s_tvalid <= 1'b0;
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d bytes, %0d buffer results checked, four idling phases",
			sb.bytes_seen, sb.results_seen);
		$display("long result hold-off with input backpressure was exercised once");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("byte_entropy_meter_test passed");
		end else begin
			$display("byte_entropy_meter_test failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/bem_pkg.sv
design/bem_log2.sv
design/bem_div.sv
design/bem_dp.sv
design/bem_ctrl.sv
design/byte_entropy_meter.sv
dv/byte_entropy_meter_test.sv
